// File: src/rau_pkg.sv
// Package for the RGBA8 alpha unpremultiply block.
// Holds widths, pipeline depth and the pipeline load-control struct.
// No dependencies.
`default_nettype none

package rau_pkg;

  // Pixel channel geometry
  localparam int CH_W      = 8;
  localparam int NUM_LANES = 3;
  localparam int TDATA_W   = 4 * CH_W;

  // Division pipeline: quotient bits resolved per stage and stage count
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = CH_W / DIV_BITS_PER_STAGE;

  // Entry stage is 0, divide stages 1..DIV_STAGES, output merge after that
  localparam int MERGE_STAGE = DIV_STAGES + 1;

  // Saturated channel value
  localparam logic [CH_W-1:0] CH_MAX = '1;

  // Per-stage load enables, shared by the lanes and the merge stage
  typedef struct packed {
    logic [MERGE_STAGE:0] load;
  } pipe_ctl_t;

endpackage : rau_pkg

`default_nettype wire

// File: src/rgba8_alpha_unpremultiply.sv
// Top level of the RGBA8 alpha unpremultiply block.
// Uses rau_pkg, three rau_lane instances (R, G, B) and rau_merge.
//
//   Channel   Dir  Fields (tdata from bit 0 up)            Sideband
//   s_*       in   in_red, in_green, in_blue, in_alpha    tlast = in_last
//   m_*       out  out_red, out_green, out_blue, out_alpha tlast = out_last
//
// One pixel per clock sustained while m_tready is high; stages are the entry stage,
// four divide stages at two quotient bits each, and the output register.
// Each pipeline stage advances when it is empty or the stage after it moves,
// so bubbles collapse and s_tready only drops when every stage holds a pixel.
// rst (synchronous) clears the stage valid bits; data registers are not reset.
`default_nettype none

module rgba8_alpha_unpremultiply
  import rau_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [TDATA_W-1:0] s_tdata,   // in_red, in_green, in_blue, in_alpha
  input  wire logic               s_tlast,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic      [TDATA_W-1:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic                    m_tlast
);

  logic [MERGE_STAGE:0]           vld;
  pipe_ctl_t                      ctl;
  logic [NUM_LANES-1:0][CH_W-1:0] lane_q;
  logic [NUM_LANES-1:0]           lane_sat;
  logic [NUM_LANES-1:0][CH_W-1:0] color;
  logic [CH_W-1:0]                alpha_out;
  logic [CH_W-1:0]                in_alpha;
  logic [CH_W-1:0]                sb_alpha [0:DIV_STAGES];
  logic                           sb_last  [0:DIV_STAGES];

  assign in_alpha = s_tdata[3*CH_W +: CH_W];

  // Stage load enables, from the output back to the input
  always_comb begin
    ctl.load[MERGE_STAGE] = !vld[MERGE_STAGE] || m_tready;
    for (int k = MERGE_STAGE - 1; k >= 0; k--) begin
      ctl.load[k] = !vld[k] || ctl.load[k+1];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctl.load[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k <= MERGE_STAGE; k++) begin
        if (ctl.load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Alpha and last flag travel beside the lanes
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      sb_alpha[0] <= in_alpha;
      sb_last[0]  <= s_tlast;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (ctl.load[k]) begin
        sb_alpha[k] <= sb_alpha[k-1];
        sb_last[k]  <= sb_last[k-1];
      end
    end
  end

  // Color lanes
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rau_lane u_lane (
      .clk   (clk),
      .chan  (s_tdata[i*CH_W +: CH_W]),
      .alpha (in_alpha),
      .ctl   (ctl),
      .quot  (lane_q[i]),
      .sat   (lane_sat[i])
    );
  end

  rau_merge u_merge (
    .clk       (clk),
    .ctl       (ctl),
    .quot      (lane_q),
    .sat       (lane_sat),
    .alpha     (sb_alpha[DIV_STAGES]),
    .last      (sb_last[DIV_STAGES]),
    .color     (color),
    .alpha_out (alpha_out),
    .last_out  (m_tlast)
  );

  assign s_tready = ctl.load[0];
  assign m_tvalid = vld[MERGE_STAGE];
  assign m_tdata  = {alpha_out, color[2], color[1], color[0]};

`ifndef SYNTHESIS
  // Input only stalls when the whole pipeline is full
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&vld))
    else $error("input stalled with an empty pipeline stage");

  // An accepted transaction lands in the entry stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted transaction lost at entry stage");

  // Transparent pixels leave with zero color
  a_transparent_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[4*CH_W-1:3*CH_W] == '0)) |-> (m_tdata[3*CH_W-1:0] == '0))
    else $error("transparent pixel with nonzero color");
`endif

endmodule : rgba8_alpha_unpremultiply

`default_nettype wire

// File: src/rau_lane.sv
// One color lane: pipelined restoring divide of (510*c + a) by 2*a.
// Depends on rau_pkg for widths and the pipeline control struct.
`default_nettype none

module rau_lane
  import rau_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [CH_W-1:0] chan,
  input  wire logic [CH_W-1:0] alpha,
  input  wire pipe_ctl_t       ctl,
  output logic      [CH_W-1:0] quot,
  output logic                 sat
);

  localparam int NUM_W = 2 * CH_W + 1;  // 510*255 + 255 fits in 17 bits
  localparam int REM_W = CH_W + 1;      // remainder stays below 2*a

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic             qbit;
  } div_res_t;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  function automatic div_res_t div_step(input logic [REM_W-1:0] rem_in,
                                        input logic             nbit,
                                        input logic [REM_W-1:0] dvs);
    logic [REM_W:0] trial;
    div_res_t       res;
    trial = {rem_in, nbit};
    if (trial >= {1'b0, dvs}) begin
      res.rem  = REM_W'(trial - {1'b0, dvs});
      res.qbit = 1'b1;
    end else begin
      res.rem  = trial[REM_W-1:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

  // Stage registers; remainder, pending low bits and divisor feed the next stage
  logic [REM_W-1:0] rem   [0:DIV_STAGES-1];
  logic [CH_W-1:0]  lo    [0:DIV_STAGES-1];
  logic [REM_W-1:0] dvs   [0:DIV_STAGES-1];
  logic [CH_W-1:0]  qacc  [0:DIV_STAGES];
  logic             sat_q [0:DIV_STAGES];

  // Entry numerator: 510*c + a, as (c << 9) - (c << 1) + a
  logic [NUM_W-1:0] num;

  always_comb begin
    num = (NUM_W'(chan) << (CH_W + 1)) - (NUM_W'(chan) << 1) + NUM_W'(alpha);
  end

  // Entry stage. Quotient fits 8 bits when c < a, so the top bits seed the remainder.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      rem[0]   <= num[NUM_W-1:CH_W];
      lo[0]    <= num[CH_W-1:0];
      dvs[0]   <= {alpha, 1'b0};
      qacc[0]  <= '0;
      sat_q[0] <= (chan >= alpha);
    end
  end

  // Divide stages, DIV_BITS_PER_STAGE quotient bits each
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [REM_W-1:0] rem_nx;
    logic [CH_W-1:0]  q_nx;

    always_comb begin
      div_res_t st;
      rem_nx = rem[k-1];
      q_nx   = qacc[k-1];
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
        st     = div_step(rem_nx, lo[k-1][CH_W-1-j], dvs[k-1]);
        rem_nx = st.rem;
        q_nx   = {q_nx[CH_W-2:0], st.qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.load[k]) begin
        qacc[k]  <= q_nx;
        sat_q[k] <= sat_q[k-1];
      end
    end

    if (k < DIV_STAGES) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctl.load[k]) begin
          rem[k] <= rem_nx;
          lo[k]  <= lo[k-1] << DIV_BITS_PER_STAGE;
          dvs[k] <= dvs[k-1];
        end
      end
    end
  end

  assign quot = qacc[DIV_STAGES];
  assign sat  = sat_q[DIV_STAGES];

endmodule : rau_lane

`default_nettype wire

// File: src/rau_merge.sv
// Output merge: applies transparent and saturation cases, registers the pixel.
// Depends on rau_pkg for widths and the pipeline control struct.
`default_nettype none

module rau_merge
  import rau_pkg::*;
(
  input  wire logic                           clk,
  input  wire pipe_ctl_t                      ctl,
  input  wire logic [NUM_LANES-1:0][CH_W-1:0] quot,
  input  wire logic [NUM_LANES-1:0]           sat,
  input  wire logic [CH_W-1:0]                alpha,
  input  wire logic                           last,
  output logic      [NUM_LANES-1:0][CH_W-1:0] color,
  output logic      [CH_W-1:0]                alpha_out,
  output logic                                last_out
);

  logic [NUM_LANES-1:0][CH_W-1:0] color_next;

  // Transparent pixel zeroes color; a channel at or above alpha saturates
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      priority if (alpha == '0) begin
        color_next[i] = '0;
      end else if (sat[i]) begin
        color_next[i] = CH_MAX;
      end else begin
        color_next[i] = quot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[MERGE_STAGE]) begin
      color     <= color_next;
      alpha_out <= alpha;
      last_out  <= last;
    end
  end

endmodule : rau_merge

`default_nettype wire
